FILE: rtl/property_path_tokenizer_top_macros.svh
// assertion macros for the property path tokenizer
// used by modules that include this header; needs clk_i and rst_ni in scope
`ifndef PROPERTY_PATH_TOKENIZER_TOP_MACROS_SVH
`define PROPERTY_PATH_TOKENIZER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PPT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ppt assertion failed");
`define PPT_NEVER(lbl, expr) \
  `PPT_ASSERT(lbl, !(expr))
`else
`define PPT_ASSERT(lbl, prop)
`define PPT_NEVER(lbl, expr)
`endif
`endif

FILE: rtl/ppt_pkg.sv
// shared types and constants of the property path tokenizer
// no dependencies
package ppt_pkg;

  // character codes the parser reacts to
  localparam logic [15:0] CH_NUL    = 16'h0000;
  localparam logic [15:0] CH_DOT    = 16'h002E;
  localparam logic [15:0] CH_SLASH  = 16'h002F;
  localparam logic [15:0] CH_LBRACK = 16'h005B;
  localparam logic [15:0] CH_RBRACK = 16'h005D;
  localparam logic [15:0] CH_LPAREN = 16'h0028;
  localparam logic [15:0] CH_RPAREN = 16'h0029;

  // character class assigned by the front end
  typedef enum logic [3:0] {
    CLS_OTHER,
    CLS_SPACE,
    CLS_DOT,
    CLS_SLASH,
    CLS_LBRACK,
    CLS_RBRACK,
    CLS_LPAREN,
    CLS_RPAREN,
    CLS_ZERO
  } cls_e;

  // classified character as queued between front and back
  typedef struct packed {
    cls_e cls;
    logic fin;
    logic ovf;
  } char_tag_t;

  typedef enum logic [1:0] {
    KIND_DIRECT   = 2'd0,
    KIND_PROPERTY = 2'd1,
    KIND_INDEXER  = 2'd2,
    KIND_ERROR    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    DRILL_IF_NEEDED = 2'd0,
    DRILL_NEVER     = 2'd1,
    DRILL_ALWAYS    = 2'd2
  } drill_e;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_BAD_CHAR     = 3'd1,
    ERR_PAREN        = 3'd2,
    ERR_OPEN_INDEXER = 3'd3,
    ERR_OVERFLOW     = 3'd4
  } err_e;

  // one descriptor on the output side
  typedef struct packed {
    kind_e        kind;
    drill_e       drill;
    logic [11:0]  start;
    logic [12:0]  len;
    err_e         code;
    logic         eop;
  } result_t;

endpackage

FILE: rtl/ppt_front.sv
// front end: classifies each character and tags it with its path offset
// depends on ppt_pkg
module ppt_front #(
  parameter int unsigned MAX_PATH_LEN = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [15:0]                          ch_i,
  input  logic                                 final_char_i,
  input  logic                                 accept_i,
  output ppt_pkg::char_tag_t                   tag_o,
  output logic [$clog2(MAX_PATH_LEN+1)-1:0]    pos_o
);

  localparam int unsigned PosW = $clog2(MAX_PATH_LEN + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_PATH_LEN);

  logic [PosW-1:0] pos_q, pos_d;
  logic            ovf;

  function automatic ppt_pkg::cls_e classify(input logic [15:0] c);
    ppt_pkg::cls_e k;
    k = ppt_pkg::CLS_OTHER;
    case (c) inside
      [16'h0009:16'h000D], 16'h0020, 16'h0085, 16'h00A0, 16'h1680,
      [16'h2000:16'h200A], 16'h2028, 16'h2029, 16'h202F, 16'h205F,
      16'h3000:          k = ppt_pkg::CLS_SPACE;
      ppt_pkg::CH_DOT:    k = ppt_pkg::CLS_DOT;
      ppt_pkg::CH_SLASH:  k = ppt_pkg::CLS_SLASH;
      ppt_pkg::CH_LBRACK: k = ppt_pkg::CLS_LBRACK;
      ppt_pkg::CH_RBRACK: k = ppt_pkg::CLS_RBRACK;
      ppt_pkg::CH_LPAREN: k = ppt_pkg::CLS_LPAREN;
      ppt_pkg::CH_RPAREN: k = ppt_pkg::CLS_RPAREN;
      ppt_pkg::CH_NUL:    k = ppt_pkg::CLS_ZERO;
      default:            k = ppt_pkg::CLS_OTHER;
    endcase
    return k;
  endfunction

  // offset counter saturates at the path limit, cleared by the final character
  assign ovf = (pos_q == PosMax);

  always_comb begin
    pos_d = pos_q;
    if (accept_i) begin
      if (final_char_i) begin
        pos_d = '0;
      end else if (!ovf) begin
        pos_d = pos_q + {{(PosW-1){1'b0}}, 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // tag for the queue
  assign tag_o.cls = classify(ch_i);
  assign tag_o.fin = final_char_i;
  assign tag_o.ovf = ovf;
  assign pos_o     = pos_q;

endmodule

FILE: rtl/ppt_queue.sv
// short register queue between the front end and the parser
// depends on property_path_tokenizer_top_macros.svh
`include "property_path_tokenizer_top_macros.svh"

module ppt_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + {{(PtrW-1){1'b0}}, 1'b1};
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + {{(PtrW-1){1'b0}}, 1'b1};
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + {{(CntW-1){1'b0}}, 1'b1};
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - {{(CntW-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `PPT_ASSERT(a_q_cnt_bound, cnt_q <= CntFull)
  `PPT_NEVER(a_q_pop_empty, pop_i && (cnt_q == '0))
  `PPT_NEVER(a_q_push_full, push_i && !pop_i && (cnt_q == CntFull))

endmodule

FILE: rtl/ppt_back.sv
// back end: path parser state machine and result buffer
// depends on ppt_pkg and property_path_tokenizer_top_macros.svh
`include "property_path_tokenizer_top_macros.svh"

module ppt_back #(
  parameter int unsigned MAX_PATH_LEN    = 4096,
  parameter int unsigned MAX_PAREN_DEPTH = 15
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              head_valid_i,
  input  ppt_pkg::char_tag_t                head_tag_i,
  input  logic [$clog2(MAX_PATH_LEN+1)-1:0] head_pos_i,
  output logic                              head_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output ppt_pkg::result_t                  res_o
);

  localparam int unsigned PosW     = $clog2(MAX_PATH_LEN + 1);
  localparam int unsigned DepW     = $clog2(MAX_PAREN_DEPTH + 2) + 1;
  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = 2;
  localparam int unsigned ResCntW  = 3;

  localparam logic signed [DepW-1:0] DZero = '0;
  localparam logic signed [DepW-1:0] DOne  = DepW'(1);
  localparam logic signed [DepW-1:0] DMax  = DepW'(MAX_PAREN_DEPTH);
  localparam logic signed [DepW-1:0] DMinN = -DMax;

  typedef enum logic [4:0] {
    MODE_START = 5'b00001,
    MODE_PROP  = 5'b00010,
    MODE_DRILL = 5'b00100,
    MODE_INDEX = 5'b01000,
    MODE_ERROR = 5'b10000
  } mode_e;

  mode_e                   mode_q, mode_d;
  logic [PosW-1:0]         seg_q, seg_d;
  logic signed [DepW-1:0]  depth_q, depth_d;
  ppt_pkg::drill_e         drill_q, drill_d;
  logic                    owp_q, owp_d;
  logic                    err_q, err_d;
  ppt_pkg::err_e           code_q, code_d;

  ppt_pkg::cls_e           cls;
  logic                    special;
  logic [PosW-1:0]         pos_next;
  logic signed [DepW-1:0]  depth_inc, depth_dec;
  logic                    feed_vld, fin_vld, sep_step, idx_done;
  ppt_pkg::result_t        feed_res, fin_res, res0, res1;
  logic [1:0]              n_res;
  logic                    room_ok;

  ppt_pkg::result_t        buf_q [ResDepth];
  logic [ResPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [ResCntW-1:0]      cnt_q;
  logic [1:0]              push_n;
  logic                    out_pop;

  // property or direct descriptor for a name ending before stop
  function automatic ppt_pkg::result_t prop_result(input logic [PosW-1:0] seg,
                                                   input logic [PosW-1:0] stop,
                                                   input logic owp,
                                                   input ppt_pkg::drill_e drill);
    ppt_pkg::result_t r;
    logic [PosW-1:0]  len;
    logic [PosW:0]    first;
    r       = '0;
    len     = stop - seg;
    first   = {1'b0, seg} + {{PosW{1'b0}}, 1'b1};
    r.drill = drill;
    if (len == '0) begin
      r.kind = ppt_pkg::KIND_DIRECT;
    end else if (owp) begin
      // strip the enclosing parentheses
      r.kind  = ppt_pkg::KIND_PROPERTY;
      r.start = 12'(first);
      r.len   = (len >= PosW'(2)) ? 13'(len - PosW'(2)) : '0;
    end else begin
      r.kind  = ppt_pkg::KIND_PROPERTY;
      r.start = 12'(seg);
      r.len   = 13'(len);
    end
    return r;
  endfunction

  function automatic ppt_pkg::result_t direct_result(input ppt_pkg::drill_e drill);
    ppt_pkg::result_t r;
    r       = '0;
    r.kind  = ppt_pkg::KIND_DIRECT;
    r.drill = drill;
    return r;
  endfunction

  assign cls       = head_tag_i.cls;
  assign special   = cls inside {ppt_pkg::CLS_DOT, ppt_pkg::CLS_SLASH,
                                 ppt_pkg::CLS_LBRACK, ppt_pkg::CLS_RBRACK};
  assign pos_next  = head_pos_i + {{(PosW-1){1'b0}}, 1'b1};
  assign depth_inc = depth_q + DOne;
  assign depth_dec = depth_q - DOne;

  // parser step for the character at the queue head
  always_comb begin
    mode_d   = mode_q;
    seg_d    = seg_q;
    depth_d  = depth_q;
    drill_d  = drill_q;
    owp_d    = owp_q;
    err_d    = err_q;
    code_d   = code_q;
    feed_vld = 1'b0;
    feed_res = '0;
    fin_vld  = 1'b0;
    fin_res  = '0;
    sep_step = 1'b0;
    idx_done = 1'b0;

    if (!err_q) begin
      if (head_tag_i.ovf) begin
        err_d  = 1'b1;
        code_d = ppt_pkg::ERR_OVERFLOW;
        mode_d = MODE_ERROR;
      end else begin
        case (mode_q)
          MODE_START: begin
            if (cls == ppt_pkg::CLS_SPACE) begin
              mode_d = MODE_START;
            end else if (cls == ppt_pkg::CLS_LBRACK) begin
              seg_d  = pos_next;
              mode_d = MODE_INDEX;
            end else begin
              seg_d   = head_pos_i;
              owp_d   = (cls == ppt_pkg::CLS_LPAREN);
              depth_d = DZero;
              mode_d  = MODE_PROP;
              if (special) begin
                // empty level right before a separator
                feed_vld = 1'b1;
                feed_res = direct_result(drill_q);
                sep_step = 1'b1;
              end else if (cls == ppt_pkg::CLS_LPAREN) begin
                depth_d = DOne;
              end else if (cls == ppt_pkg::CLS_RPAREN) begin
                depth_d = -DOne;
              end
            end
          end
          MODE_PROP: begin
            if ((depth_q > DZero) || !special) begin
              if (cls == ppt_pkg::CLS_LPAREN) begin
                depth_d = depth_inc;
                if (depth_inc > DMax) begin
                  err_d  = 1'b1;
                  code_d = ppt_pkg::ERR_OVERFLOW;
                  mode_d = MODE_ERROR;
                end
              end else if (cls == ppt_pkg::CLS_RPAREN) begin
                depth_d = depth_dec;
                if (depth_dec < DMinN) begin
                  err_d  = 1'b1;
                  code_d = ppt_pkg::ERR_OVERFLOW;
                  mode_d = MODE_ERROR;
                end
              end
            end else begin
              feed_vld = 1'b1;
              feed_res = prop_result(seg_q, head_pos_i, owp_q, drill_q);
              sep_step = 1'b1;
            end
          end
          MODE_DRILL: begin
            case (cls)
              ppt_pkg::CLS_SPACE: mode_d = MODE_DRILL;
              ppt_pkg::CLS_DOT: begin
                drill_d = ppt_pkg::DRILL_NEVER;
                mode_d  = MODE_START;
              end
              ppt_pkg::CLS_SLASH: begin
                drill_d = ppt_pkg::DRILL_ALWAYS;
                mode_d  = MODE_START;
              end
              ppt_pkg::CLS_LBRACK: begin
                seg_d  = pos_next;
                mode_d = MODE_INDEX;
              end
              ppt_pkg::CLS_ZERO: begin
                seg_d   = head_pos_i;
                owp_d   = 1'b0;
                depth_d = DZero;
                mode_d  = MODE_PROP;
              end
              default: begin
                err_d  = 1'b1;
                code_d = ppt_pkg::ERR_BAD_CHAR;
                mode_d = MODE_ERROR;
              end
            endcase
          end
          MODE_INDEX: begin
            if (cls == ppt_pkg::CLS_RBRACK) begin
              feed_vld       = 1'b1;
              feed_res       = '0;
              feed_res.kind  = ppt_pkg::KIND_INDEXER;
              feed_res.drill = drill_q;
              feed_res.start = 12'(seg_q);
              feed_res.len   = 13'(head_pos_i - seg_q);
              if (head_tag_i.fin) begin
                idx_done = 1'b1;
              end else begin
                drill_d = ppt_pkg::DRILL_NEVER;
                mode_d  = MODE_DRILL;
              end
            end
          end
          default: mode_d = mode_q;
        endcase

        // separator that closed a level
        if (sep_step) begin
          drill_d = ppt_pkg::DRILL_NEVER;
          case (cls)
            ppt_pkg::CLS_DOT:   mode_d = MODE_START;
            ppt_pkg::CLS_SLASH: begin
              drill_d = ppt_pkg::DRILL_ALWAYS;
              mode_d  = MODE_START;
            end
            ppt_pkg::CLS_LBRACK: begin
              seg_d  = pos_next;
              mode_d = MODE_INDEX;
            end
            default: begin
              err_d  = 1'b1;
              code_d = ppt_pkg::ERR_BAD_CHAR;
              mode_d = MODE_ERROR;
            end
          endcase
        end
      end
    end

    // end of path: close the open level, report a latched error, restart
    if (head_tag_i.fin) begin
      if (!err_d && !idx_done) begin
        case (mode_d)
          MODE_START, MODE_DRILL: begin
            fin_vld = 1'b1;
            fin_res = direct_result(drill_d);
          end
          MODE_PROP: begin
            if (depth_d > DZero) begin
              err_d  = 1'b1;
              code_d = ppt_pkg::ERR_PAREN;
            end else begin
              fin_vld = 1'b1;
              fin_res = prop_result(seg_d, pos_next, owp_d, drill_d);
            end
          end
          MODE_INDEX: begin
            err_d  = 1'b1;
            code_d = ppt_pkg::ERR_OPEN_INDEXER;
          end
          default: fin_vld = 1'b0;
        endcase
      end
      if (err_d) begin
        fin_vld      = 1'b1;
        fin_res      = '0;
        fin_res.kind = ppt_pkg::KIND_ERROR;
        fin_res.code = code_d;
      end
      mode_d  = MODE_START;
      seg_d   = '0;
      depth_d = DZero;
      drill_d = ppt_pkg::DRILL_IF_NEEDED;
      owp_d   = 1'b0;
      err_d   = 1'b0;
      code_d  = ppt_pkg::ERR_NONE;
    end
  end

  // order the results of this step and mark the last one of a path
  always_comb begin
    res0  = feed_vld ? feed_res : fin_res;
    res1  = fin_res;
    n_res = {1'b0, feed_vld} + {1'b0, fin_vld};
    if (head_tag_i.fin) begin
      if (n_res == 2'd2) begin
        res1.eop = 1'b1;
      end else begin
        res0.eop = 1'b1;
      end
    end
  end

  // take the head only when the result buffer has room for all its results
  assign room_ok    = ({1'b0, cnt_q} + {2'b00, n_res}) <= (ResCntW + 1)'(ResDepth);
  assign head_pop_o = head_valid_i && room_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_START;
      seg_q   <= '0;
      depth_q <= DZero;
      drill_q <= ppt_pkg::DRILL_IF_NEEDED;
      owp_q   <= 1'b0;
      err_q   <= 1'b0;
      code_q  <= ppt_pkg::ERR_NONE;
    end else if (head_pop_o) begin
      mode_q  <= mode_d;
      seg_q   <= seg_d;
      depth_q <= depth_d;
      drill_q <= drill_d;
      owp_q   <= owp_d;
      err_q   <= err_d;
      code_q  <= code_d;
    end
  end

  // result buffer, up to two writes and one read per cycle
  assign push_n      = head_pop_o ? n_res : 2'd0;
  assign out_valid_o = (cnt_q != '0);
  assign out_pop     = out_valid_o && !out_stall_i;
  assign res_o       = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      buf_q[wr_ptr_q] <= res0;
    end
    if (push_n == 2'd2) begin
      buf_q[wr_ptr_q + ResPtrW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + ResPtrW'(push_n);
      rd_ptr_q <= rd_ptr_q + ResPtrW'(out_pop);
      cnt_q    <= cnt_q + ResCntW'(push_n) - ResCntW'(out_pop);
    end
  end

  `PPT_ASSERT(a_res_cnt_bound, cnt_q <= ResCntW'(ResDepth))
  `PPT_ASSERT(a_fin_restarts, (head_pop_o && head_tag_i.fin) |=> ((mode_q == MODE_START) && !err_q && (depth_q == DZero)))
  `PPT_ASSERT(a_error_ends_path, (out_valid_o && (res_o.kind == ppt_pkg::KIND_ERROR)) |-> res_o.eop)

endmodule

FILE: rtl/property_path_tokenizer_top.sv
// Property path tokenizer: one 16-bit character per cycle in, level descriptors out.
// Each character is queued, then parsed into the registered result buffer, which offers its descriptors.
// Throughput: one character per cycle while in_stall_o is low; a character that gives two descriptors (a
// level plus path end, or level plus error) has them leave the result buffer one by one via its single read port.
// Reset: asynchronous, active low; clears queue, offset counter, parser and result buffer.
// Depends on ppt_pkg, ppt_front, ppt_queue, ppt_back.
module property_path_tokenizer_top #(
  parameter int unsigned MAX_PATH_LEN    = 4096,
  parameter int unsigned MAX_PAREN_DEPTH = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] ch_i,
  input  logic        final_char_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [1:0]  drill_mode_o,
  output logic [11:0] seg_start_o,
  output logic [12:0] seg_length_o,
  output logic [2:0]  error_code_o,
  output logic        end_of_path_o
);

  localparam int unsigned PosW   = $clog2(MAX_PATH_LEN + 1);
  localparam int unsigned TagW   = $bits(ppt_pkg::char_tag_t);
  localparam int unsigned QDataW = TagW + PosW;
  localparam int unsigned QDepth = 4;

  logic                in_xfer;
  ppt_pkg::char_tag_t  front_tag;
  logic [PosW-1:0]     front_pos;
  logic                q_valid, q_pop;
  logic [QDataW-1:0]   q_data;
  ppt_pkg::char_tag_t  head_tag;
  logic [PosW-1:0]     head_pos;
  ppt_pkg::result_t    res;

  assign in_xfer = in_valid_i && !in_stall_o;

  // classify and tag
  ppt_front #(
    .MAX_PATH_LEN (MAX_PATH_LEN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ch_i         (ch_i),
    .final_char_i (final_char_i),
    .accept_i     (in_xfer),
    .tag_o        (front_tag),
    .pos_o        (front_pos)
  );

  // decoupling queue
  ppt_queue #(
    .DATA_W (QDataW),
    .DEPTH  (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_xfer),
    .data_i  ({front_tag, front_pos}),
    .full_o  (in_stall_o),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  assign head_tag = ppt_pkg::char_tag_t'(q_data[QDataW-1:PosW]);
  assign head_pos = q_data[PosW-1:0];

  // parser and result buffer
  ppt_back #(
    .MAX_PATH_LEN    (MAX_PATH_LEN),
    .MAX_PAREN_DEPTH (MAX_PAREN_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_tag_i   (head_tag),
    .head_pos_i   (head_pos),
    .head_pop_o   (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .res_o        (res)
  );

  assign kind_o        = res.kind;
  assign drill_mode_o  = res.drill;
  assign seg_start_o   = res.start;
  assign seg_length_o  = res.len;
  assign error_code_o  = res.code;
  assign end_of_path_o = res.eop;

endmodule

FILE: dv/property_path_tokenizer_top_tb.sv
// testbench for property_path_tokenizer_top: streams paths in, checks every descriptor
// against a cycle-free predictor of the tokenizer kept in this file
// depends on ppt_pkg and the tokenizer RTL
module property_path_tokenizer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppt_pkg::*;

  localparam int unsigned MAX_LEN      = 4096;
  localparam int          MAX_DEPTH    = 15;
  localparam int unsigned RANDOM_CHARS = 350;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef logic [15:0] unit_q_t[$];

  // parser position within the path
  typedef enum logic [2:0] {
    LS_START,
    LS_NAME,
    LS_AFTER,
    LS_INDEX,
    LS_ERROR,
    LS_DONE
  } level_state_e;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [15:0] ch_i         = '0;
  logic        final_char_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [1:0]  kind_o;
  logic [1:0]  drill_mode_o;
  logic [11:0] seg_start_o;
  logic [12:0] seg_length_o;
  logic [2:0]  error_code_o;
  logic        end_of_path_o;

  property_path_tokenizer_top #(
    .MAX_PATH_LEN   (MAX_LEN),
    .MAX_PAREN_DEPTH(MAX_DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .ch_i         (ch_i),
    .final_char_i (final_char_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .drill_mode_o (drill_mode_o),
    .seg_start_o  (seg_start_o),
    .seg_length_o (seg_length_o),
    .error_code_o (error_code_o),
    .end_of_path_o(end_of_path_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // descriptors still owed by the block, oldest first
  result_t     pending_descr_q[$];
  int unsigned fail_count = 0;

  // sender pacing and receiver hold-off request
  bit          tx_gapless = 1'b0;
  int unsigned hold_req   = 0;
  int unsigned hold_ack   = 0;
  int unsigned rx_run_left = 0;

  // tokenizer state as predicted
  level_state_e lvl_state;
  int unsigned  pos_cnt;
  int unsigned  seg_begin;
  int           depth;
  drill_e       drill;
  bit           paren_open;
  bit           err_seen;
  err_e         err_cause;

  // descriptors produced by the character being predicted
  result_t step_descr[2];
  int      step_cnt;

  function automatic void clear_parse_state();
    lvl_state  = LS_START;
    pos_cnt    = 0;
    seg_begin  = 0;
    depth      = 0;
    drill      = DRILL_IF_NEEDED;
    paren_open = 1'b0;
    err_seen   = 1'b0;
    err_cause  = ERR_NONE;
  endfunction

  function automatic bit is_blank(logic [15:0] c);
    return (c >= 16'd9 && c <= 16'd13) || c == 16'h0020 || c == 16'h0085 ||
           c == 16'h00A0 || c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A) ||
           c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
           c == 16'h3000;
  endfunction

  function automatic bit is_level_sep(logic [15:0] c);
    return c == CH_DOT || c == CH_SLASH || c == CH_LBRACK || c == CH_RBRACK;
  endfunction

  function automatic void add_descr(kind_e k, drill_e d, int unsigned s, int unsigned n,
                                    err_e code);
    result_t r;
    if (step_cnt >= 2) return;
    r.kind  = k;
    r.drill = d;
    r.start = s[11:0];
    r.len   = n[12:0];
    r.code  = code;
    r.eop   = 1'b0;
    step_descr[step_cnt] = r;
    step_cnt++;
  endfunction

  function automatic void latch_error(err_e code);
    err_seen  = 1'b1;
    err_cause = code;
    lvl_state = LS_ERROR;
  endfunction

  // name level ends: empty gives direct, parenthesised drops its outer characters
  function automatic void close_name(int unsigned end_pos);
    int unsigned n;
    n = end_pos - seg_begin;
    if (n == 0)
      add_descr(KIND_DIRECT, drill, 0, 0, ERR_NONE);
    else if (paren_open)
      add_descr(KIND_PROPERTY, drill, seg_begin + 1, (n >= 2) ? n - 2 : 0, ERR_NONE);
    else
      add_descr(KIND_PROPERTY, drill, seg_begin, n, ERR_NONE);
  endfunction

  // one character through the level parser; a level change may rescan it
  function automatic void parse_unit(logic [15:0] c, bit fin);
    int unsigned p;
    bit rescan;
    p = pos_cnt;
    do begin
      rescan = 1'b0;
      case (lvl_state)
        LS_START: begin
          if (!is_blank(c)) begin
            if (c == CH_LBRACK) begin
              seg_begin = p + 1;
              lvl_state = LS_INDEX;
            end else begin
              seg_begin  = p;
              paren_open = (c == CH_LPAREN);
              depth      = 0;
              lvl_state  = LS_NAME;
              rescan     = 1'b1;
            end
          end
        end
        LS_NAME: begin
          if (depth > 0 || !is_level_sep(c)) begin
            if (c == CH_LPAREN) begin
              depth++;
              if (depth > MAX_DEPTH) latch_error(ERR_OVERFLOW);
            end else if (c == CH_RPAREN) begin
              depth--;
              if (depth < -MAX_DEPTH) latch_error(ERR_OVERFLOW);
            end
          end else begin
            close_name(p);
            lvl_state = LS_AFTER;
            drill     = DRILL_NEVER;
            rescan    = 1'b1;
          end
        end
        LS_AFTER: begin
          if (!is_blank(c)) begin
            if (c == CH_DOT) begin
              drill     = DRILL_NEVER;
              lvl_state = LS_START;
            end else if (c == CH_SLASH) begin
              drill     = DRILL_ALWAYS;
              lvl_state = LS_START;
            end else if (c == CH_LBRACK || c == CH_NUL) begin
              lvl_state = LS_START;
              rescan    = 1'b1;
            end else begin
              latch_error(ERR_BAD_CHAR);
            end
          end
        end
        LS_INDEX: begin
          if (c == CH_RBRACK) begin
            add_descr(KIND_INDEXER, drill, seg_begin, p - seg_begin, ERR_NONE);
            if (fin) begin
              lvl_state = LS_DONE;
            end else begin
              lvl_state = LS_AFTER;
              drill     = DRILL_NEVER;
            end
          end
        end
        default: ;
      endcase
    end while (rescan);
  endfunction

  // expected descriptors for one accepted character
  function automatic void predict_char(logic [15:0] c, bit fin);
    step_cnt = 0;
    if (!err_seen) begin
      if (pos_cnt >= MAX_LEN) begin
        latch_error(ERR_OVERFLOW);
      end else begin
        parse_unit(c, fin);
        pos_cnt++;
      end
    end
    if (fin) begin
      if (!err_seen) begin
        case (lvl_state)
          LS_START, LS_AFTER: add_descr(KIND_DIRECT, drill, 0, 0, ERR_NONE);
          LS_NAME: begin
            if (depth > 0) latch_error(ERR_PAREN);
            else close_name(pos_cnt);
          end
          LS_INDEX: latch_error(ERR_OPEN_INDEXER);
          default: ;
        endcase
      end
      if (err_seen) add_descr(KIND_ERROR, DRILL_IF_NEEDED, 0, 0, err_cause);
      if (step_cnt > 0) step_descr[step_cnt - 1].eop = 1'b1;
      clear_parse_state();
    end
    for (int i = 0; i < step_cnt; i++) pending_descr_q.push_back(step_descr[i]);
  endfunction

  // random character sources
  function automatic logic [15:0] space_unit();
    case ($urandom_range(7))
      0: return 16'($urandom_range(9, 13));
      1: return 16'h0020;
      2: return 16'h0085;
      3: return 16'h00A0;
      4: return 16'h1680;
      5: return 16'($urandom_range(16'h2000, 16'h200A));
      6: return ($urandom_range(1) != 0) ? 16'h2028 : 16'h2029;
      default: begin
        case ($urandom_range(2))
          0: return 16'h202F;
          1: return 16'h205F;
          default: return 16'h3000;
        endcase
      end
    endcase
  endfunction

  // anything that is neither a level separator nor a parenthesis
  function automatic logic [15:0] name_unit();
    logic [15:0] u;
    if ($urandom_range(9) < 7) return 16'h0061 + 16'($urandom_range(25));
    do
      u = 16'($urandom);
    while (is_level_sep(u) || u == CH_LPAREN || u == CH_RPAREN);
    return u;
  endfunction

  function automatic logic [15:0] noise_unit();
    case ($urandom_range(7))
      0: return CH_DOT;
      1: return CH_SLASH;
      2: return CH_LBRACK;
      3: return CH_RBRACK;
      4: return ($urandom_range(1) != 0) ? CH_LPAREN : CH_RPAREN;
      5: return ($urandom_range(3) == 0) ? CH_NUL : space_unit();
      default: return name_unit();
    endcase
  endfunction

  // sender gaps: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (tx_gapless || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic idle(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // one character transfer, then an optional gap
  task automatic send_char(input logic [15:0] c, input bit fin);
    int unsigned gap;
    in_valid_i   <= 1'b1;
    ch_i         <= c;
    final_char_i <= fin;
    do
      @(posedge clk_i);
    while (in_stall_o);
    predict_char(c, fin);
    gap = pick_gap();
    if (gap > 0) idle(gap);
  endtask

  task automatic send_path(input unit_q_t path);
    foreach (path[i]) send_char(path[i], i == path.size() - 1);
  endtask

  task automatic send_text(input string s);
    unit_q_t path;
    for (int i = 0; i < s.len(); i++) path.push_back(16'(s[i]));
    send_path(path);
  endtask

  // level kinds and drill modes
  task automatic test_levels();
    send_text("a");
    send_text("Ab.c/d");
    send_text(".");
    send_text("a..b");
    send_text("[0]");
    send_text("a[x] ");
    send_text(" \t(a.b).c");
    send_text("()");
  endtask

  // whitespace codes, extreme code units, zero unit after an indexer
  task automatic test_special_units();
    unit_q_t path;
    path = '{16'h3000, 16'h0061, 16'h00A0, 16'hFFFF, CH_LBRACK, 16'h0031, CH_RBRACK,
             CH_NUL, 16'h0062};
    send_path(path);
    path = '{16'h0061, CH_DOT, 16'h2028, 16'h0085, 16'h0062};
    send_path(path);
    path = '{16'hFFFF};
    send_path(path);
    path = '{CH_NUL};
    send_path(path);
  endtask

  // bad character, open parenthesis, open indexer, surplus close
  task automatic test_errors();
    send_text("a]");
    send_text("(a");
    send_text("(");
    send_text("[ab");
    send_text("a).b");
    send_text("x/[y]z");
    send_text("a]bc.d");
  endtask

  // nesting limits in both directions
  task automatic test_overflow();
    unit_q_t path;
    tx_gapless = 1'b1;
    // nesting one beyond the limit
    repeat (MAX_DEPTH + 1) path.push_back(CH_LPAREN);
    path.push_back(16'h0061);
    send_path(path);
    // deepest legal nesting
    path.delete();
    repeat (MAX_DEPTH) path.push_back(CH_LPAREN);
    path.push_back(16'h0071);
    repeat (MAX_DEPTH) path.push_back(CH_RPAREN);
    send_path(path);
    // surplus closes beyond the limit
    path.delete();
    path.push_back(16'h0061);
    repeat (MAX_DEPTH + 1) path.push_back(CH_RPAREN);
    path.push_back(CH_DOT);
    path.push_back(16'h0062);
    send_path(path);
    tx_gapless = 1'b0;
  endtask

  // receiver holds off while a dense path keeps coming
  task automatic test_backpressure();
    unit_q_t path;
    idle(1);
    hold_req <= hold_req + 1;
    idle(2);
    repeat (20) begin
      path.push_back(16'h0061 + 16'($urandom_range(25)));
      path.push_back(CH_LBRACK);
      path.push_back(16'h0037);
      path.push_back(CH_RBRACK);
      path.push_back(CH_DOT);
    end
    path.push_back(16'h007A);
    tx_gapless = 1'b1;
    send_path(path);
    tx_gapless = 1'b0;
  endtask

  // mostly well-formed paths with random content, some noise and corrupted paths
  task automatic test_random_paths();
    unit_q_t     path;
    int unsigned sent;
    int unsigned levels;
    int unsigned shape;
    bit          prev_index;
    sent = 0;
    while (sent < RANDOM_CHARS) begin
      path.delete();
      tx_gapless = ($urandom_range(7) == 0);
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 12)) path.push_back(noise_unit());
      end else begin
        levels     = $urandom_range(1, 5);
        prev_index = 1'b0;
        if ($urandom_range(3) == 0) path.push_back(space_unit());
        for (int lvl = 0; lvl < levels; lvl++) begin
          // 0-4 name, 5-6 parenthesised name, 7-8 indexer, 9 empty
          shape = $urandom_range(9);
          if (lvl > 0) begin
            if ($urandom_range(3) == 0) path.push_back(space_unit());
            if (shape >= 7 && shape <= 8 && $urandom_range(2) == 0) begin
              // indexer follows with no separator
            end else if (prev_index && shape < 5 && $urandom_range(3) == 0) begin
              path.push_back(CH_NUL);
            end else begin
              path.push_back(($urandom_range(1) != 0) ? CH_DOT : CH_SLASH);
            end
            if ($urandom_range(3) == 0) path.push_back(space_unit());
          end
          case (shape)
            0, 1, 2, 3, 4: repeat ($urandom_range(1, 6)) path.push_back(name_unit());
            5, 6: begin
              path.push_back(CH_LPAREN);
              repeat ($urandom_range(0, 4))
                path.push_back(($urandom_range(4) == 0) ? CH_DOT : name_unit());
              if ($urandom_range(3) == 0) begin
                path.push_back(CH_LPAREN);
                path.push_back(name_unit());
                path.push_back(CH_RPAREN);
              end
              path.push_back(CH_RPAREN);
            end
            7, 8: begin
              path.push_back(CH_LBRACK);
              repeat ($urandom_range(0, 5)) begin
                case ($urandom_range(5))
                  0: path.push_back(CH_DOT);
                  1: path.push_back(CH_LBRACK);
                  2: path.push_back(space_unit());
                  default: path.push_back(name_unit());
                endcase
              end
              path.push_back(CH_RBRACK);
            end
            default: ;
          endcase
          prev_index = (shape == 7 || shape == 8);
        end
        if ($urandom_range(4) == 0) path.push_back(space_unit());
        if (path.size() > 0 && $urandom_range(99) < 15)
          path[$urandom_range(path.size() - 1)] = noise_unit();
      end
      if (path.size() == 0) path.push_back(space_unit());
      send_path(path);
      sent += path.size();
    end
    tx_gapless = 1'b0;
  endtask

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk_i) begin : rx_pace
    int unsigned pick;
    if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      out_stall_i <= 1'b1;
      rx_run_left <= HOLD_CYCLES;
    end else if (rx_run_left > 1) begin
      rx_run_left <= rx_run_left - 1;
    end else begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        out_stall_i <= 1'b0;
        rx_run_left <= $urandom_range(1, 8);
      end else if (pick < 70) begin
        out_stall_i <= 1'b0;
        rx_run_left <= $urandom_range(20, 80);
      end else if (pick < 93) begin
        out_stall_i <= 1'b1;
        rx_run_left <= $urandom_range(1, 3);
      end else begin
        out_stall_i <= 1'b1;
        rx_run_left <= $urandom_range(8, 30);
      end
    end
  end

  task automatic compare_field(input string field, input logic [12:0] want,
                               input logic [12:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  // every descriptor transfer against the oldest pending one
  always @(posedge clk_i) begin : descr_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_descr_q.size() == 0) begin
        $display("%0t: expected no descriptor, got kind %0d start %0d length %0d code %0d",
                 $time, kind_o, seg_start_o, seg_length_o, error_code_o);
        fail_count++;
      end else begin
        want = pending_descr_q.pop_front();
        compare_field("kind", 13'(want.kind), 13'(kind_o));
        compare_field("drill_mode", 13'(want.drill), 13'(drill_mode_o));
        compare_field("seg_start", 13'(want.start), 13'(seg_start_o));
        compare_field("seg_length", want.len, seg_length_o);
        compare_field("error_code", 13'(want.code), 13'(error_code_o));
        compare_field("end_of_path", 13'(want.eop), 13'(end_of_path_o));
      end
    end
  end

  // test sequence
  initial begin
    clear_parse_state();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_levels();
    test_special_units();
    test_errors();
    test_overflow();
    test_backpressure();
    test_random_paths();
    in_valid_i <= 1'b0;
    while (pending_descr_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** property_path_tokenizer_top: PASSED **");
    end else begin
      $display("** property_path_tokenizer_top: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100ms;
    $display("** property_path_tokenizer_top: FAILED **");
    $finish;
  end

endmodule
